// ----- rtl/wrp_pkg.sv -----
// Shared types, constants and codes of the weighted region partitioner.
`default_nettype none
package wrp_pkg;

  localparam int unsigned POS_W      = 32;
  localparam int unsigned SPAN_W     = 16;
  localparam int unsigned DEPTH_W    = 24;
  localparam int unsigned REACH_W    = 33;
  localparam int unsigned WEIGHT_W   = 48;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - POS_W - REACH_W;
  localparam int unsigned DIV_STEPS  = WEIGHT_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam int unsigned MAX_ENTRIES_DEFAULT = 1048576;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_PADDING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_PADDING   = 2'd2;

  localparam logic [CFG_W-1:0] REGION_COUNT_RESET  = 16'd1;
  localparam logic [CFG_W-1:0] START_PADDING_RESET = 16'd1;
  localparam logic [CFG_W-1:0] END_PADDING_RESET   = 16'd1;

  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};

  localparam logic KIND_WEIGH = 1'b0;
  localparam logic KIND_CUT   = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_STEP = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  typedef struct packed {
    logic [POS_W-1:0]   start;
    logic [REACH_W-1:0] stop;
    logic               final_flag;
  } region_t;

endpackage
`default_nettype wire

// ----- rtl/weighted_region_partitioner.sv -----
// Depth-weighted region partitioner: weigh pass, serial divider, cut pass.
// A cut pass entry is captured, then in the step state emits any regions it closes
// to the output slots, waiting while the output is still full; a weigh pass entry is
// captured, then applied in one update step. No new entry is taken until that ends.
// The last weigh pass entry then runs the bit-serial total/region_count divide and
// loads the target.
// Reset (rst_ni low, asynchronous): registers back to 1, sums and cut state cleared.
`default_nettype none
module weighted_region_partitioner #(
  parameter int unsigned MAX_ENTRIES = wrp_pkg::MAX_ENTRIES_DEFAULT
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire  [wrp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire  [wrp_pkg::CFG_W-1:0]         cfg_data_i,
  input  wire                               s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // position[31:0], span_length[47:32], depth[71:48]
  input  wire  [wrp_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // kind
  input  wire                               s_axis_tuser_i,
  input  wire                               s_axis_tlast_i,
  output logic                              m_axis_tvalid_o,
  input  wire                               m_axis_tready_i,
  // region_start[31:0], region_end[64:32], zero[71:65]
  output logic [wrp_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  output logic                              m_axis_tlast_o
);
  import wrp_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] ENTRY_LIMIT = CNT_W'(MAX_ENTRIES);

  state_e state_q, state_d;

  logic [CFG_W-1:0] region_count_q, start_pad_q, end_pad_q;

  logic                kind_q, last_q;
  logic [POS_W-1:0]    pos_q;
  logic [SPAN_W-1:0]   span_q;
  logic [DEPTH_W-1:0]  depth_q;

  logic [WEIGHT_W-1:0] weight_total_q, weight_total_d;
  logic [CNT_W-1:0]    entry_total_q, entry_total_d;
  logic [WEIGHT_W-1:0] weight_target_q, weight_target_d;
  logic                few_q, few_d;
  logic [WEIGHT_W-1:0] weight_run_q, weight_run_d;
  logic [REACH_W-1:0]  span_reach_q, span_reach_d;
  logic [POS_W-1:0]    open_start_q, open_start_d;
  logic                first_open_q, first_open_d;
  logic                pending_q, pending_d;

  logic [WEIGHT_W-1:0]  quo_q, quo_d;
  logic [CFG_W-1:0]     rem_q, rem_d;
  logic [CFG_W-1:0]     divisor_q, divisor_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

  region_t slot0_q, slot0_d, slot1_q, slot1_d;
  logic    ov0_q, ov0_d, ov1_q, ov1_d;

  logic                 in_acc, out_pop;
  logic [WEIGHT_W-1:0]  w;
  logic [WEIGHT_W:0]    total_sum, run_sum;
  logic [CFG_W-1:0]     rc;
  logic [CNT_W-1:0]     entry_n;
  logic [REACH_W-1:0]   reach, reach_base, reach_n;
  logic [WEIGHT_W-1:0]  run_base;
  logic                 cut, empty_blk, first_n;
  logic [POS_W-1:0]     open_n, cut_start, fin_start;
  logic [REACH_W:0]     fin_end_sum;
  region_t              cut_res, fin_res;
  logic [CFG_W:0]       rem_sh;
  logic                 div_ge;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign out_pop         = ov0_q & m_axis_tready_i;
  assign m_axis_tvalid_o = ov0_q;
  assign m_axis_tdata_o  = {OUT_PAD_W'(0), slot0_q.stop, slot0_q.start};
  assign m_axis_tlast_o  = slot0_q.final_flag;

  always_comb begin
    w         = (depth_q == '0) ? WEIGHT_W'(1) : WEIGHT_W'(depth_q);
    rc        = (region_count_q == '0) ? CFG_W'(1) : region_count_q;
    total_sum = {1'b0, weight_total_q} + {1'b0, w};
    entry_n   = (entry_total_q < ENTRY_LIMIT) ? entry_total_q + CNT_W'(1) : entry_total_q;
    reach     = {1'b0, pos_q} + REACH_W'(span_q);

    cut = pending_q && !few_q && (weight_run_q >= weight_target_q) &&
          ({1'b0, pos_q} >= span_reach_q);
    empty_blk  = !pending_q || cut;
    cut_start  = (first_open_q && open_start_q >= POS_W'(start_pad_q)) ?
                 open_start_q - POS_W'(start_pad_q) : open_start_q;
    first_n    = cut ? 1'b0 : first_open_q;
    open_n     = empty_blk ? pos_q : open_start_q;
    run_base   = cut ? '0 : weight_run_q;
    reach_base = cut ? '0 : span_reach_q;
    run_sum    = {1'b0, run_base} + {1'b0, w};
    reach_n    = (reach > reach_base) ? reach : reach_base;

    if (few_q) begin
      fin_start   = (open_n >= POS_W'(start_pad_q)) ? open_n - POS_W'(start_pad_q) : '0;
      fin_end_sum = {1'b0, reach} + (REACH_W + 1)'(end_pad_q);
    end else begin
      fin_start   = (first_n && open_n >= POS_W'(start_pad_q)) ?
                    open_n - POS_W'(start_pad_q) : open_n;
      fin_end_sum = {1'b0, reach_n} + (REACH_W + 1)'(end_pad_q);
    end
    cut_res = '{start: cut_start, stop: {1'b0, pos_q}, final_flag: 1'b0};
    fin_res = '{start: fin_start, stop: fin_end_sum[REACH_W-1:0], final_flag: 1'b1};

    rem_sh = {rem_q, quo_q[WEIGHT_W-1]};
    div_ge = rem_sh >= {1'b0, divisor_q};

    state_d         = state_q;
    weight_total_d  = weight_total_q;
    entry_total_d   = entry_total_q;
    weight_target_d = weight_target_q;
    few_d           = few_q;
    weight_run_d    = weight_run_q;
    span_reach_d    = span_reach_q;
    open_start_d    = open_start_q;
    first_open_d    = first_open_q;
    pending_d       = pending_q;
    quo_d           = quo_q;
    rem_d           = rem_q;
    divisor_d       = divisor_q;
    cnt_d           = cnt_q;
    slot0_d         = slot0_q;
    slot1_d         = slot1_q;
    ov0_d           = ov0_q;
    ov1_d           = ov1_q;

    if (out_pop) begin
      slot0_d = slot1_q;
      ov0_d   = ov1_q;
      ov1_d   = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        if (kind_q == KIND_WEIGH) begin
          if (last_q) begin
            quo_d           = total_sum[WEIGHT_W] ? WEIGHT_MAX : total_sum[WEIGHT_W-1:0];
            rem_d           = '0;
            divisor_d       = rc;
            cnt_d           = '0;
            few_d           = ({CFG_W'(0), entry_n} <= {CNT_W'(0), rc});
            weight_total_d  = '0;
            entry_total_d   = '0;
            weight_run_d    = '0;
            span_reach_d    = '0;
            open_start_d    = '0;
            first_open_d    = 1'b1;
            pending_d       = 1'b0;
            state_d         = S_DIV;
          end else begin
            weight_total_d = total_sum[WEIGHT_W] ? WEIGHT_MAX : total_sum[WEIGHT_W-1:0];
            entry_total_d  = entry_n;
            state_d        = S_IDLE;
          end
        end else if (!ov0_q) begin
          if (cut) begin
            slot0_d = cut_res;
            ov0_d   = 1'b1;
            slot1_d = fin_res;
            ov1_d   = last_q;
          end else if (last_q) begin
            slot0_d = fin_res;
            ov0_d   = 1'b1;
          end
          if (last_q) begin
            weight_run_d = '0;
            span_reach_d = '0;
            open_start_d = '0;
            first_open_d = 1'b1;
            pending_d    = 1'b0;
          end else begin
            weight_run_d = run_sum[WEIGHT_W] ? WEIGHT_MAX : run_sum[WEIGHT_W-1:0];
            span_reach_d = reach_n;
            open_start_d = open_n;
            first_open_d = first_n;
            pending_d    = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        rem_d = div_ge ? rem_sh[CFG_W-1:0] - divisor_q : rem_sh[CFG_W-1:0];
        quo_d = {quo_q[WEIGHT_W-2:0], div_ge};
        cnt_d = cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        weight_target_d = (quo_q == '0) ? WEIGHT_W'(1) : quo_q;
        state_d         = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      region_count_q  <= REGION_COUNT_RESET;
      start_pad_q     <= START_PADDING_RESET;
      end_pad_q       <= END_PADDING_RESET;
      weight_total_q  <= '0;
      entry_total_q   <= '0;
      weight_target_q <= WEIGHT_W'(1);
      few_q           <= 1'b0;
      weight_run_q    <= '0;
      span_reach_q    <= '0;
      open_start_q    <= '0;
      first_open_q    <= 1'b1;
      pending_q       <= 1'b0;
      cnt_q           <= '0;
      ov0_q           <= 1'b0;
      ov1_q           <= 1'b0;
    end else begin
      state_q         <= state_d;
      weight_total_q  <= weight_total_d;
      entry_total_q   <= entry_total_d;
      weight_target_q <= weight_target_d;
      few_q           <= few_d;
      weight_run_q    <= weight_run_d;
      span_reach_q    <= span_reach_d;
      open_start_q    <= open_start_d;
      first_open_q    <= first_open_d;
      pending_q       <= pending_d;
      cnt_q           <= cnt_d;
      ov0_q           <= ov0_d;
      ov1_q           <= ov1_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_REGION_COUNT:  region_count_q <= cfg_data_i;
          REG_START_PADDING: start_pad_q    <= cfg_data_i;
          REG_END_PADDING:   end_pad_q      <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q  <= s_axis_tuser_i;
      last_q  <= s_axis_tlast_i;
      pos_q   <= s_axis_tdata_i[POS_W-1:0];
      span_q  <= s_axis_tdata_i[POS_W +: SPAN_W];
      depth_q <= s_axis_tdata_i[POS_W + SPAN_W +: DEPTH_W];
    end
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
    slot0_q   <= slot0_d;
    slot1_q   <= slot1_d;
  end

endmodule
`default_nettype wire

// ----- rtl/wrp_checker.sv -----
// Port-level checks of the weighted region partitioner, bound to its top level.
`default_nettype none
module wrp_checker (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire                             s_axis_tvalid_i,
  input wire                             s_axis_tready_o,
  input wire                             m_axis_tvalid_o,
  input wire                             m_axis_tready_i,
  input wire [wrp_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  input wire                             m_axis_tlast_o
);
  import wrp_pkg::*;

  logic s_acc;
  assign s_acc = s_axis_tvalid_i & s_axis_tready_o;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output transaction dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output payload changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready_o)
    else $error("input taken in the cycle after a transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("region appeared without an entry being processed");

endmodule

bind weighted_region_partitioner wrp_checker u_wrp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
`default_nettype wire
